>>> design/htnm_pkg.sv
// Shared definitions for the height-to-normal-map block.
// Holds frame limits, field widths, register indexes, request codes and the stencil source type.
// No dependencies.
package htnm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int DIM_W = 11;
    localparam int PIX_W = 8;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Request kinds on the input channel.
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic [DIM_W-1:0] MIN_WIDTH_VAL  = DIM_W'(1);
    localparam logic [DIM_W-1:0] MIN_HEIGHT_VAL = DIM_W'(3);
    localparam logic [DIM_W-1:0] MAX_WIDTH_VAL  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_HEIGHT_VAL = DIM_W'(MAX_HEIGHT);

    // Blue is floor((130050 - dx^2 - dy^2) / 510). The numerator is halved and then
    // divided by 255 with a reciprocal multiply that is exact for values below 66052.
    localparam logic [16:0] BLUE_BIAS    = 17'd130050;
    localparam logic [15:0] DIV255_MAGIC = 16'h8081;
    localparam int          DIV255_SHIFT = 23;

    typedef enum logic [1:0] {
        SRC_PIXEL,
        SRC_DRAIN_LAST,
        SRC_DRAIN_TOP
    } src_t;

endpackage

>>> design/htnm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// A read and a write of the same address in one cycle return the old data.
// No dependencies.
module htnm_ram #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]    rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/height_to_normal_map.sv
// Height map to RGB normal map, streaming, one request per clock.
// A request passes through stage 1, stage 2 and the output register, and can be held in any
// of them while the output stalls.
// Throughput: one request per cycle; the pipeline stalls only on back pressure at m_ready.
// Reset (aresetn low, synchronous): counters, valids and frame state clear, frame size goes
// to 1024 x 1024. The line stores are not cleared and need no clearing pass.
module height_to_normal_map (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_we,
    input  logic [htnm_pkg::IDX_W-1:0]      cfg_index,
    input  logic [htnm_pkg::DIM_W-1:0]      cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [htnm_pkg::PIX_W-1:0]      s_height_value,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [htnm_pkg::PIX_W-1:0]      m_normal_red,
    output logic [htnm_pkg::PIX_W-1:0]      m_normal_green,
    output logic [htnm_pkg::PIX_W-1:0]      m_normal_blue,
    output logic [htnm_pkg::COL_W-1:0]      m_out_col,
    output logic [htnm_pkg::ROW_W-1:0]      m_out_row,
    output logic                            m_frame_done
);

    // ------------------------------------------------------------------------
    // Frame geometry. The registers hold the clamped size, so everything
    // downstream sees only legal widths and heights.
    // ------------------------------------------------------------------------
    logic [htnm_pkg::DIM_W-1:0] frame_width_reg;
    logic [htnm_pkg::DIM_W-1:0] frame_height_reg;
    logic [htnm_pkg::DIM_W-1:0] frame_width_next;
    logic [htnm_pkg::DIM_W-1:0] frame_height_next;
    logic                       cfg_hit;

    // Input-side frame state. A frame runs through two phases: pixels of all
    // rows come in (rows 1..H-2 come out one row late), then drain requests
    // produce row H-1 and finally row 0.
    logic [htnm_pkg::COL_W-1:0] in_col_reg;
    logic [htnm_pkg::COL_W-1:0] in_col_next;
    logic [htnm_pkg::ROW_W-1:0] in_row_reg;
    logic [htnm_pkg::ROW_W-1:0] in_row_next;
    logic [htnm_pkg::COL_W-1:0] drain_col_reg;
    logic [htnm_pkg::COL_W-1:0] drain_col_next;
    logic                       drain_top_reg;
    logic                       drain_top_next;
    logic                       loaded_reg;
    logic                       loaded_next;

    // Handshake and pipeline control.
    logic accept;
    logic pix_take;
    logic drain_take;
    logic pix_emit;
    logic load_s1;
    logic out_adv;
    logic s2_adv;
    logic s1_adv;

    // Stencil addressing for the request at the input.
    logic [htnm_pkg::COL_W-1:0] cur_x;
    logic [htnm_pkg::COL_W-1:0] x_left;
    logic [htnm_pkg::COL_W-1:0] x_right;
    logic                       col_last;
    logic                       row_last;
    logic [htnm_pkg::DIM_W-1:0] h_last;
    logic                       last_par;
    htnm_pkg::src_t             cur_src;
    logic                       cur_cp;
    logic [htnm_pkg::ROW_W-1:0] cur_row;
    logic                       cur_done;
    logic [htnm_pkg::COL_W-1:0] ring_a0_raddr;
    logic [htnm_pkg::COL_W-1:0] ring_b0_raddr;
    logic [htnm_pkg::COL_W-1:0] top0_raddr;
    logic                       ring_a_we;
    logic                       ring_b_we;
    logic                       top_we;
    logic                       second_we;

    // Store read data, valid in stage 1.
    logic [htnm_pkg::PIX_W-1:0] ring_a0_q;
    logic [htnm_pkg::PIX_W-1:0] ring_a1_q;
    logic [htnm_pkg::PIX_W-1:0] ring_b0_q;
    logic [htnm_pkg::PIX_W-1:0] ring_b1_q;
    logic [htnm_pkg::PIX_W-1:0] top0_q;
    logic [htnm_pkg::PIX_W-1:0] top1_q;
    logic [htnm_pkg::PIX_W-1:0] second_q;

    // Stage 1: the request's side information, aligned with the RAM read data.
    logic                       s1_valid_reg;
    htnm_pkg::src_t             s1_src_reg;
    logic                       s1_cp_reg;
    logic [htnm_pkg::PIX_W-1:0] s1_below_reg;
    logic [htnm_pkg::COL_W-1:0] s1_col_reg;
    logic [htnm_pkg::ROW_W-1:0] s1_row_reg;
    logic                       s1_done_reg;

    logic [htnm_pkg::PIX_W-1:0] nb_above;
    logic [htnm_pkg::PIX_W-1:0] nb_left;
    logic [htnm_pkg::PIX_W-1:0] nb_right;
    logic [htnm_pkg::PIX_W-1:0] nb_below;
    logic [9:0]                 dx_sum;
    logic [9:0]                 dy_sum;
    logic [htnm_pkg::PIX_W-1:0] dx_mag;
    logic [htnm_pkg::PIX_W-1:0] dy_mag;
    logic [15:0]                dx_sq;
    logic [15:0]                dy_sq;

    // Stage 2: red, green and the sum of squares.
    logic                       s2_valid_reg;
    logic [htnm_pkg::PIX_W-1:0] s2_red_reg;
    logic [htnm_pkg::PIX_W-1:0] s2_green_reg;
    logic [16:0]                s2_sq_sum_reg;
    logic [htnm_pkg::COL_W-1:0] s2_col_reg;
    logic [htnm_pkg::ROW_W-1:0] s2_row_reg;
    logic                       s2_done_reg;

    logic [16:0]                blue_num;
    logic [15:0]                blue_half;
    logic [31:0]                blue_prod;

    // Output register.
    logic                       m_valid_reg;
    logic [htnm_pkg::PIX_W-1:0] m_red_reg;
    logic [htnm_pkg::PIX_W-1:0] m_green_reg;
    logic [htnm_pkg::PIX_W-1:0] m_blue_reg;
    logic [htnm_pkg::COL_W-1:0] m_col_reg;
    logic [htnm_pkg::ROW_W-1:0] m_row_reg;
    logic                       m_done_reg;

    // ------------------------------------------------------------------------
    // Configuration. A write of either register restarts the frame; writes to
    // indexes past the two registers are dropped.
    // ------------------------------------------------------------------------
    assign cfg_hit = cfg_we && (cfg_index == htnm_pkg::REG_FRAME_WIDTH ||
                                cfg_index == htnm_pkg::REG_FRAME_HEIGHT);

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we && cfg_index == htnm_pkg::REG_FRAME_WIDTH) begin
            if (cfg_wdata < htnm_pkg::MIN_WIDTH_VAL) begin
                frame_width_next = htnm_pkg::MIN_WIDTH_VAL;
            end else if (cfg_wdata > htnm_pkg::MAX_WIDTH_VAL) begin
                frame_width_next = htnm_pkg::MAX_WIDTH_VAL;
            end else begin
                frame_width_next = cfg_wdata;
            end
        end
        if (cfg_we && cfg_index == htnm_pkg::REG_FRAME_HEIGHT) begin
            if (cfg_wdata < htnm_pkg::MIN_HEIGHT_VAL) begin
                frame_height_next = htnm_pkg::MIN_HEIGHT_VAL;
            end else if (cfg_wdata > htnm_pkg::MAX_HEIGHT_VAL) begin
                frame_height_next = htnm_pkg::MAX_HEIGHT_VAL;
            end else begin
                frame_height_next = cfg_wdata;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline control. Each stage moves when the one after it is empty or
    // moving, so bubbles close up behind a stalled output.
    // ------------------------------------------------------------------------
    assign out_adv = !m_valid_reg || m_ready;
    assign s2_adv  = !s2_valid_reg || out_adv;
    assign s1_adv  = !s1_valid_reg || s2_adv;
    assign s_ready = s1_adv;

    assign accept     = s_valid && s_ready;
    // Pixels are ignored while a finished frame waits for its drain requests,
    // and drain requests are ignored while no frame is loaded.
    assign pix_take   = accept && !s_req_type && !loaded_reg;
    assign drain_take = accept && s_req_type && loaded_reg;
    assign pix_emit   = pix_take && (in_row_reg >= htnm_pkg::ROW_W'(2));
    assign load_s1    = pix_emit || drain_take;

    // ------------------------------------------------------------------------
    // Stencil addressing. Left and right neighbors wrap inside the row.
    // ------------------------------------------------------------------------
    assign h_last   = frame_height_reg - htnm_pkg::DIM_W'(1);
    assign last_par = h_last[0];
    assign cur_x    = s_req_type ? drain_col_reg : in_col_reg;
    assign col_last = ({1'b0, cur_x} + htnm_pkg::DIM_W'(1)) == frame_width_reg;
    assign row_last = ({1'b0, in_row_reg} + htnm_pkg::DIM_W'(1)) == frame_height_reg;
    assign x_left   = (cur_x == '0) ? htnm_pkg::COL_W'(frame_width_reg - htnm_pkg::DIM_W'(1))
                                    : cur_x - htnm_pkg::COL_W'(1);
    assign x_right  = col_last ? '0 : cur_x + htnm_pkg::COL_W'(1);

    // The "center" ring is the one read at the pixel's own column for the
    // above value; the other ring (or the top-row copy) supplies left and right.
    always_comb begin
        if (!s_req_type) begin
            cur_src = htnm_pkg::SRC_PIXEL;
            cur_cp  = in_row_reg[0];
            cur_row = in_row_reg - htnm_pkg::ROW_W'(1);
        end else if (!drain_top_reg) begin
            cur_src = htnm_pkg::SRC_DRAIN_LAST;
            cur_cp  = !last_par;
            cur_row = htnm_pkg::ROW_W'(h_last);
        end else begin
            cur_src = htnm_pkg::SRC_DRAIN_TOP;
            cur_cp  = last_par;
            cur_row = '0;
        end
    end

    assign cur_done      = s_req_type && drain_top_reg && col_last;
    assign ring_a0_raddr = cur_cp ? x_left : cur_x;
    assign ring_b0_raddr = cur_cp ? cur_x : x_left;
    assign top0_raddr    = (cur_src == htnm_pkg::SRC_DRAIN_TOP) ? x_left : cur_x;

    // Rows alternate between the two rings by parity; rows 0 and 1 are also
    // kept aside for the wrap-around of the last row and of row 0.
    assign ring_a_we = pix_take && !in_row_reg[0];
    assign ring_b_we = pix_take && in_row_reg[0];
    assign top_we    = pix_take && (in_row_reg == '0);
    assign second_we = pix_take && (in_row_reg == htnm_pkg::ROW_W'(1));

    // Each ring and the top-row copy is held twice so that the left and the
    // right neighbor can be read in the same cycle.
    htnm_ram #(.DATA_WIDTH(htnm_pkg::PIX_W), .DEPTH(htnm_pkg::MAX_WIDTH)) u_ring_a0 (
        .aclk(aclk), .we(ring_a_we), .waddr(in_col_reg), .wdata(s_height_value),
        .re(load_s1), .raddr(ring_a0_raddr), .rdata(ring_a0_q)
    );
    htnm_ram #(.DATA_WIDTH(htnm_pkg::PIX_W), .DEPTH(htnm_pkg::MAX_WIDTH)) u_ring_a1 (
        .aclk(aclk), .we(ring_a_we), .waddr(in_col_reg), .wdata(s_height_value),
        .re(load_s1), .raddr(x_right), .rdata(ring_a1_q)
    );
    htnm_ram #(.DATA_WIDTH(htnm_pkg::PIX_W), .DEPTH(htnm_pkg::MAX_WIDTH)) u_ring_b0 (
        .aclk(aclk), .we(ring_b_we), .waddr(in_col_reg), .wdata(s_height_value),
        .re(load_s1), .raddr(ring_b0_raddr), .rdata(ring_b0_q)
    );
    htnm_ram #(.DATA_WIDTH(htnm_pkg::PIX_W), .DEPTH(htnm_pkg::MAX_WIDTH)) u_ring_b1 (
        .aclk(aclk), .we(ring_b_we), .waddr(in_col_reg), .wdata(s_height_value),
        .re(load_s1), .raddr(x_right), .rdata(ring_b1_q)
    );
    htnm_ram #(.DATA_WIDTH(htnm_pkg::PIX_W), .DEPTH(htnm_pkg::MAX_WIDTH)) u_top0 (
        .aclk(aclk), .we(top_we), .waddr(in_col_reg), .wdata(s_height_value),
        .re(load_s1), .raddr(top0_raddr), .rdata(top0_q)
    );
    htnm_ram #(.DATA_WIDTH(htnm_pkg::PIX_W), .DEPTH(htnm_pkg::MAX_WIDTH)) u_top1 (
        .aclk(aclk), .we(top_we), .waddr(in_col_reg), .wdata(s_height_value),
        .re(load_s1), .raddr(x_right), .rdata(top1_q)
    );
    htnm_ram #(.DATA_WIDTH(htnm_pkg::PIX_W), .DEPTH(htnm_pkg::MAX_WIDTH)) u_second (
        .aclk(aclk), .we(second_we), .waddr(in_col_reg), .wdata(s_height_value),
        .re(load_s1), .raddr(cur_x), .rdata(second_q)
    );

    // ------------------------------------------------------------------------
    // Frame counters.
    // ------------------------------------------------------------------------
    always_comb begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        drain_col_next = drain_col_reg;
        drain_top_next = drain_top_reg;
        loaded_next    = loaded_reg;
        if (cfg_hit) begin
            in_col_next    = '0;
            in_row_next    = '0;
            drain_col_next = '0;
            drain_top_next = 1'b0;
            loaded_next    = 1'b0;
        end else if (pix_take) begin
            if (col_last) begin
                in_col_next = '0;
                if (row_last) begin
                    in_row_next    = '0;
                    loaded_next    = 1'b1;
                    drain_col_next = '0;
                    drain_top_next = 1'b0;
                end else begin
                    in_row_next = in_row_reg + htnm_pkg::ROW_W'(1);
                end
            end else begin
                in_col_next = in_col_reg + htnm_pkg::COL_W'(1);
            end
        end else if (drain_take) begin
            if (col_last) begin
                drain_col_next = '0;
                if (drain_top_reg) begin
                    drain_top_next = 1'b0;
                    loaded_next    = 1'b0;
                end else begin
                    drain_top_next = 1'b1;
                end
            end else begin
                drain_col_next = drain_col_reg + htnm_pkg::COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: pick the four neighbors out of the store read data and form the
    // encoded red and green plus the squared gradients.
    // ------------------------------------------------------------------------
    always_comb begin
        nb_above = s1_cp_reg ? ring_b0_q : ring_a0_q;
        nb_left  = s1_cp_reg ? ring_a0_q : ring_b0_q;
        nb_right = s1_cp_reg ? ring_a1_q : ring_b1_q;
        nb_below = s1_below_reg;
        unique case (s1_src_reg)
            htnm_pkg::SRC_PIXEL: begin
                nb_below = s1_below_reg;
            end
            htnm_pkg::SRC_DRAIN_LAST: begin
                nb_below = top0_q;
            end
            htnm_pkg::SRC_DRAIN_TOP: begin
                nb_left  = top0_q;
                nb_right = top1_q;
                nb_below = second_q;
            end
            default: begin
                nb_below = s1_below_reg;
            end
        endcase
    end

    assign dx_sum = {2'b00, nb_left} + 10'd255 - {2'b00, nb_right};
    assign dy_sum = {2'b00, nb_below} + 10'd255 - {2'b00, nb_above};
    assign dx_mag = (nb_left >= nb_right) ? nb_left - nb_right : nb_right - nb_left;
    assign dy_mag = (nb_below >= nb_above) ? nb_below - nb_above : nb_above - nb_below;
    assign dx_sq  = {8'h00, dx_mag} * {8'h00, dx_mag};
    assign dy_sq  = {8'h00, dy_mag} * {8'h00, dy_mag};

    // ------------------------------------------------------------------------
    // Stage 2: blue = floor((130050 - sum) / 510), done as a halving followed
    // by an exact reciprocal multiply for the division by 255.
    // ------------------------------------------------------------------------
    assign blue_num  = htnm_pkg::BLUE_BIAS - s2_sq_sum_reg;
    assign blue_half = blue_num[16:1];
    assign blue_prod = {16'h0000, blue_half} * {16'h0000, htnm_pkg::DIV255_MAGIC};

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= htnm_pkg::MAX_WIDTH_VAL;
            frame_height_reg <= htnm_pkg::MAX_HEIGHT_VAL;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            drain_col_reg    <= '0;
            drain_top_reg    <= 1'b0;
            loaded_reg       <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            drain_col_reg    <= drain_col_next;
            drain_top_reg    <= drain_top_next;
            loaded_reg       <= loaded_next;
            if (s1_adv) begin
                s1_valid_reg <= load_s1;
            end
            if (s2_adv) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_s1) begin
            s1_src_reg   <= cur_src;
            s1_cp_reg    <= cur_cp;
            s1_below_reg <= s_height_value;
            s1_col_reg   <= cur_x;
            s1_row_reg   <= cur_row;
            s1_done_reg  <= cur_done;
        end
        if (s2_adv && s1_valid_reg) begin
            s2_red_reg    <= dx_sum[8:1];
            s2_green_reg  <= dy_sum[8:1];
            s2_sq_sum_reg <= {1'b0, dx_sq} + {1'b0, dy_sq};
            s2_col_reg    <= s1_col_reg;
            s2_row_reg    <= s1_row_reg;
            s2_done_reg   <= s1_done_reg;
        end
        if (out_adv && s2_valid_reg) begin
            m_red_reg   <= s2_red_reg;
            m_green_reg <= s2_green_reg;
            m_blue_reg  <= blue_prod[htnm_pkg::DIV255_SHIFT +: htnm_pkg::PIX_W];
            m_col_reg   <= s2_col_reg;
            m_row_reg   <= s2_row_reg;
            m_done_reg  <= s2_done_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_normal_red   = m_red_reg;
    assign m_normal_green = m_green_reg;
    assign m_normal_blue  = m_blue_reg;
    assign m_out_col      = m_col_reg;
    assign m_out_row      = m_row_reg;
    assign m_frame_done   = m_done_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    // The frame-done flag only ever marks a pixel of row 0.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_reg |-> m_row_reg == '0)
        else $error("frame_done on a row other than 0");

    // A loaded frame waits with the input position back at the origin.
    assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg |-> in_col_reg == '0 && in_row_reg == '0)
        else $error("frame loaded with input position not at origin");

    // Column counters stay inside the configured row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, in_col_reg} < frame_width_reg && {1'b0, drain_col_reg} < frame_width_reg)
        else $error("column counter past frame width");

    // A drain request on a loaded frame always enters stage 1 on the next cycle; from there it
    // passes through stage 2 to the output register when the output side does not stall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        drain_take && m_ready && $past(m_ready) |=> s1_valid_reg)
        else $error("drain request lost in stage 1");

endmodule
